### rtl/hrhp_pkg.sv
// Shared types, codes, byte classes and match tables for the HTTP request header parser.
// Depends on nothing; every other file in rtl uses it by scoped names.
package hrhp_pkg;

  typedef enum logic [4:0] {
    PH_METHOD_START = 5'd0,
    PH_METHOD       = 5'd1,
    PH_URI          = 5'd2,
    PH_V_H          = 5'd3,
    PH_V_T1         = 5'd4,
    PH_V_T2         = 5'd5,
    PH_V_P          = 5'd6,
    PH_V_SLASH      = 5'd7,
    PH_MAJ_START    = 5'd8,
    PH_MAJ          = 5'd9,
    PH_MIN_START    = 5'd10,
    PH_MIN          = 5'd11,
    PH_NL1          = 5'd12,
    PH_LINE_START   = 5'd13,
    PH_NAME         = 5'd14,
    PH_SPACE        = 5'd15,
    PH_VALUE        = 5'd16,
    PH_NL2          = 5'd17,
    PH_NL3          = 5'd18,
    PH_DONE         = 5'd19,
    PH_ERROR        = 5'd20
  } phase_t;

  localparam logic [1:0] VERDICT_MORE = 2'd0;
  localparam logic [1:0] VERDICT_DONE = 2'd1;
  localparam logic [1:0] VERDICT_BAD  = 2'd2;

  localparam logic [1:0] ENC_NONE    = 2'd0;
  localparam logic [1:0] ENC_DEFLATE = 2'd1;
  localparam logic [1:0] ENC_GZIP    = 2'd2;

  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_URI     = 2'd1;
  localparam logic [1:0] KIND_REFERER = 2'd2;
  localparam logic [1:0] KIND_AGENT   = 2'd3;

  // Bit positions in the header match flags.
  localparam int HDR_AE  = 0;
  localparam int HDR_REF = 1;
  localparam int HDR_UA  = 2;

  localparam logic [4:0] NAME_POS_MAX = 5'd31;
  localparam logic [2:0] DEFLATE_LEN  = 3'd7;
  localparam logic [2:0] GZIP_LEN     = 3'd4;

  localparam logic [4:0] HDR_LEN [3] = '{5'd15, 5'd7, 5'd10};

  localparam logic [7:0] AE_CHARS [16] = '{
    "a", "c", "c", "e", "p", "t", "-", "e", "n", "c", "o", "d", "i", "n", "g", 8'h00
  };
  localparam logic [7:0] REF_CHARS [16] = '{
    "r", "e", "f", "e", "r", "e", "r", 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };
  localparam logic [7:0] UA_CHARS [16] = '{
    "u", "s", "e", "r", "-", "a", "g", "e", "n", "t", 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };
  localparam logic [7:0] DEFLATE_CHARS [8] = '{
    "d", "e", "f", "l", "a", "t", "e", 8'h00
  };
  localparam logic [7:0] GZIP_CHARS [4] = '{"g", "z", "i", "p"};

  typedef struct packed {
    phase_t     phase;
    logic [1:0] enc;
    logic [4:0] name_pos;
    logic [2:0] match;
    logic [2:0] gzip_prog;
    logic [2:0] defl_prog;
    logic [1:0] found;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    PH_METHOD_START, ENC_NONE, 5'd0, 3'd0, 3'd0, 3'd0, 2'd0
  };

  typedef struct packed {
    logic [1:0] verdict;
    logic [1:0] compression;
    logic [1:0] kind;
    logic [7:0] data;
  } result_t;

  function automatic logic is_ctl(input logic [7:0] b);
    return (b <= 8'd31) || (b == 8'd127);
  endfunction

  function automatic logic is_sep(input logic [7:0] b);
    logic s;
    s = 1'b0;
    unique case (b)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/",
      "[", "]", "?", "=", "{", "}", " ", "\t": s = 1'b1;
      default: s = 1'b0;
    endcase
    return s;
  endfunction

  function automatic logic is_token(input logic [7:0] b);
    return !b[7] && !is_ctl(b) && !is_sep(b);
  endfunction

  function automatic logic is_dig(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return ((b >= "A") && (b <= "Z")) ? (b + 8'd32) : b;
  endfunction

  function automatic logic [7:0] hdr_char(input logic [1:0] which, input logic [3:0] pos);
    logic [7:0] c;
    c = 8'h00;
    unique case (which)
      2'd0:    c = AE_CHARS[pos];
      2'd1:    c = REF_CHARS[pos];
      2'd2:    c = UA_CHARS[pos];
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### rtl/hrhp_step.sv
// Combinational next-state and result logic for one request byte.
// Depends on hrhp_pkg for phases, codes, byte classes and match tables.
module hrhp_step (
  input  hrhp_pkg::parse_state_t state_in,
  input  logic [7:0]             byte_in,
  input  logic                   restart,
  output hrhp_pkg::parse_state_t state_next,
  output hrhp_pkg::result_t      result
);

  hrhp_pkg::parse_state_t st;
  hrhp_pkg::parse_state_t nx;
  logic [1:0] verdict;
  logic [1:0] kind;
  logic [7:0] lb;
  logic [4:0] nb_pos;
  logic [2:0] nb_flags;
  logic [2:0] nb_flags_out;
  logic [4:0] nb_pos_out;
  logic [2:0] dn;
  logic [2:0] gn;
  logic       hd;
  logic       hg;
  logic [2:0] colon_flags;

  always_comb begin
    st = restart ? hrhp_pkg::STATE_RESET : state_in;
    lb = hrhp_pkg::to_lower(byte_in);

    // Header name matcher; a new line starts from position zero with all names live.
    nb_pos   = (st.phase == hrhp_pkg::PH_LINE_START) ? 5'd0 : st.name_pos;
    nb_flags = (st.phase == hrhp_pkg::PH_LINE_START) ? 3'b111 : st.match;
    nb_flags_out = nb_flags;
    colon_flags  = st.match;
    for (int i = 0; i < 3; i++) begin
      if (nb_pos >= hrhp_pkg::HDR_LEN[i] ||
          lb != hrhp_pkg::hdr_char(2'(i), nb_pos[3:0])) begin
        nb_flags_out[i] = 1'b0;
      end
      if (st.name_pos != hrhp_pkg::HDR_LEN[i]) begin
        colon_flags[i] = 1'b0;
      end
    end
    nb_pos_out = (nb_pos < hrhp_pkg::NAME_POS_MAX) ? nb_pos + 5'd1 : nb_pos;

    // Substring searches over Accept-Encoding values.
    hd = 1'b0;
    if (st.defl_prog >= hrhp_pkg::DEFLATE_LEN) begin
      dn = hrhp_pkg::DEFLATE_LEN;
      hd = 1'b1;
    end else if (lb == hrhp_pkg::DEFLATE_CHARS[st.defl_prog]) begin
      dn = st.defl_prog + 3'd1;
      hd = (dn == hrhp_pkg::DEFLATE_LEN);
    end else begin
      dn = (lb == hrhp_pkg::DEFLATE_CHARS[0]) ? 3'd1 : 3'd0;
    end

    hg = 1'b0;
    if (st.gzip_prog >= hrhp_pkg::GZIP_LEN) begin
      gn = hrhp_pkg::GZIP_LEN;
      hg = 1'b1;
    end else if (lb == hrhp_pkg::GZIP_CHARS[st.gzip_prog[1:0]]) begin
      gn = st.gzip_prog + 3'd1;
      hg = (gn == hrhp_pkg::GZIP_LEN);
    end else begin
      gn = (lb == hrhp_pkg::GZIP_CHARS[0]) ? 3'd1 : 3'd0;
    end

    nx      = st;
    verdict = hrhp_pkg::VERDICT_MORE;
    kind    = hrhp_pkg::KIND_NONE;

    unique case (st.phase)
      hrhp_pkg::PH_METHOD_START: begin
        if (hrhp_pkg::is_token(byte_in)) nx.phase = hrhp_pkg::PH_METHOD;
        else verdict = hrhp_pkg::VERDICT_BAD;
      end
      hrhp_pkg::PH_METHOD: begin
        if (byte_in == " ") nx.phase = hrhp_pkg::PH_URI;
        else if (!hrhp_pkg::is_token(byte_in)) verdict = hrhp_pkg::VERDICT_BAD;
      end
      hrhp_pkg::PH_URI: begin
        if (byte_in == " ") nx.phase = hrhp_pkg::PH_V_H;
        else if (hrhp_pkg::is_ctl(byte_in)) verdict = hrhp_pkg::VERDICT_BAD;
        else kind = hrhp_pkg::KIND_URI;
      end
      hrhp_pkg::PH_V_H: begin
        if (byte_in == "H") nx.phase = hrhp_pkg::PH_V_T1;
        else verdict = hrhp_pkg::VERDICT_BAD;
      end
      hrhp_pkg::PH_V_T1: begin
        if (byte_in == "T") nx.phase = hrhp_pkg::PH_V_T2;
        else verdict = hrhp_pkg::VERDICT_BAD;
      end
      hrhp_pkg::PH_V_T2: begin
        if (byte_in == "T") nx.phase = hrhp_pkg::PH_V_P;
        else verdict = hrhp_pkg::VERDICT_BAD;
      end
      hrhp_pkg::PH_V_P: begin
        if (byte_in == "P") nx.phase = hrhp_pkg::PH_V_SLASH;
        else verdict = hrhp_pkg::VERDICT_BAD;
      end
      hrhp_pkg::PH_V_SLASH: begin
        if (byte_in == "/") nx.phase = hrhp_pkg::PH_MAJ_START;
        else verdict = hrhp_pkg::VERDICT_BAD;
      end
      hrhp_pkg::PH_MAJ_START: begin
        if (hrhp_pkg::is_dig(byte_in)) nx.phase = hrhp_pkg::PH_MAJ;
        else verdict = hrhp_pkg::VERDICT_BAD;
      end
      hrhp_pkg::PH_MAJ: begin
        if (byte_in == ".") nx.phase = hrhp_pkg::PH_MIN_START;
        else if (!hrhp_pkg::is_dig(byte_in)) verdict = hrhp_pkg::VERDICT_BAD;
      end
      hrhp_pkg::PH_MIN_START: begin
        if (hrhp_pkg::is_dig(byte_in)) nx.phase = hrhp_pkg::PH_MIN;
        else verdict = hrhp_pkg::VERDICT_BAD;
      end
      hrhp_pkg::PH_MIN: begin
        if (byte_in == "\r") nx.phase = hrhp_pkg::PH_NL1;
        else if (!hrhp_pkg::is_dig(byte_in)) verdict = hrhp_pkg::VERDICT_BAD;
      end
      hrhp_pkg::PH_NL1: begin
        if (byte_in == "\n") nx.phase = hrhp_pkg::PH_LINE_START;
        else verdict = hrhp_pkg::VERDICT_BAD;
      end
      hrhp_pkg::PH_LINE_START: begin
        // The finished line's encoding lands here, whatever this byte turns out to be.
        if (st.match[hrhp_pkg::HDR_AE]) begin
          if (st.found[0]) nx.enc = hrhp_pkg::ENC_DEFLATE;
          if (st.found[1]) nx.enc = hrhp_pkg::ENC_GZIP;
        end
        if (byte_in == "\r") begin
          nx.phase = hrhp_pkg::PH_NL3;
        end else if (!hrhp_pkg::is_token(byte_in)) begin
          verdict = hrhp_pkg::VERDICT_BAD;
        end else begin
          nx.phase     = hrhp_pkg::PH_NAME;
          nx.name_pos  = nb_pos_out;
          nx.match     = nb_flags_out;
          nx.gzip_prog = 3'd0;
          nx.defl_prog = 3'd0;
          nx.found     = 2'd0;
        end
      end
      hrhp_pkg::PH_NAME: begin
        if (byte_in == ":") begin
          nx.phase = hrhp_pkg::PH_SPACE;
          nx.match = colon_flags;
        end else if (!hrhp_pkg::is_token(byte_in)) begin
          verdict = hrhp_pkg::VERDICT_BAD;
        end else begin
          nx.name_pos = nb_pos_out;
          nx.match    = nb_flags_out;
        end
      end
      hrhp_pkg::PH_SPACE: begin
        if (byte_in == " ") nx.phase = hrhp_pkg::PH_VALUE;
        else verdict = hrhp_pkg::VERDICT_BAD;
      end
      hrhp_pkg::PH_VALUE: begin
        if (byte_in == "\r") begin
          nx.phase = hrhp_pkg::PH_NL2;
        end else if (hrhp_pkg::is_ctl(byte_in)) begin
          verdict = hrhp_pkg::VERDICT_BAD;
        end else begin
          if (st.match[hrhp_pkg::HDR_AE]) begin
            nx.defl_prog = dn;
            nx.gzip_prog = gn;
            nx.found     = st.found | {hg, hd};
          end
          if (st.match[hrhp_pkg::HDR_REF]) kind = hrhp_pkg::KIND_REFERER;
          else if (st.match[hrhp_pkg::HDR_UA]) kind = hrhp_pkg::KIND_AGENT;
        end
      end
      hrhp_pkg::PH_NL2: begin
        if (byte_in == "\n") nx.phase = hrhp_pkg::PH_LINE_START;
        else verdict = hrhp_pkg::VERDICT_BAD;
      end
      hrhp_pkg::PH_NL3: begin
        if (byte_in == "\n") begin
          verdict  = hrhp_pkg::VERDICT_DONE;
          nx.phase = hrhp_pkg::PH_DONE;
        end else begin
          verdict = hrhp_pkg::VERDICT_BAD;
        end
      end
      hrhp_pkg::PH_DONE: verdict = hrhp_pkg::VERDICT_DONE;
      default:           verdict = hrhp_pkg::VERDICT_BAD;
    endcase

    if (verdict == hrhp_pkg::VERDICT_BAD) begin
      nx.phase = hrhp_pkg::PH_ERROR;
      kind     = hrhp_pkg::KIND_NONE;
    end

    state_next         = nx;
    result.verdict     = verdict;
    result.compression = nx.enc;
    result.kind        = kind;
    result.data        = (kind != hrhp_pkg::KIND_NONE) ? byte_in : 8'h00;
  end

endmodule

### rtl/http_request_header_parser.sv
// Streaming HTTP/1.1 request line and header parser, one request byte per beat.
// A byte is registered in s1_byte, passes the combinational hrhp_step and lands in res.
// Throughput: one byte per cycle unless out_stall holds the result register.
// Reset clears the pipeline valids and returns the parser to method start.
// Depends on hrhp_pkg and hrhp_step.
module http_request_header_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] byte_in,
  input  logic       restart,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] verdict,
  output logic [1:0] compression,
  output logic [1:0] byte_kind,
  output logic [7:0] byte_out
);

  logic                   s1_valid;
  logic [7:0]             s1_byte;
  logic                   s1_restart;
  hrhp_pkg::parse_state_t state;
  hrhp_pkg::parse_state_t state_next;
  hrhp_pkg::result_t      step_result;
  hrhp_pkg::result_t      res;
  logic                   advance;

  // The pipeline moves whenever the result register is free or being emptied.
  assign advance  = !(out_valid && out_stall);
  assign in_stall = s1_valid && !advance;

  hrhp_step u_step (
    .state_in   (state),
    .byte_in    (s1_byte),
    .restart    (s1_restart),
    .state_next (state_next),
    .result     (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= hrhp_pkg::STATE_RESET;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
        if (s1_valid) begin
          state <= state_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte    <= byte_in;
      s1_restart <= restart;
    end
    if (advance && s1_valid) begin
      res <= step_result;
    end
  end

  assign verdict     = res.verdict;
  assign compression = res.compression;
  assign byte_kind   = res.kind;
  assign byte_out    = res.data;

endmodule

### sim/http_request_header_parser_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for http_request_header_parser: streams request bytes, tracks the
// parser state alongside the block and checks every field of every result beat.
// Depends on hrhp_pkg for phase, verdict, encoding and capture codes, and on the parser RTL.
module http_request_header_parser_tb;
  import hrhp_pkg::*;

  localparam int ITEM_TARGET = 1650;
  localparam logic [7:0] CR  = 8'h0D;
  localparam logic [7:0] LF  = 8'h0A;
  localparam logic [7:0] TAB = 8'h09;
  localparam int FOUND_DEFLATE = 0;
  localparam int FOUND_GZIP    = 1;

  typedef enum int {MIX_HEADERS, ENCODING_HEADERS, CAPTURE_HEADERS, LONG_NAMES} header_mix_t;
  typedef enum int {HK_ACCEPT, HK_REFERER, HK_AGENT, HK_NEAR, HK_OTHER, HK_LONG} header_kind_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] byte_in;
  logic       restart;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] verdict;
  logic [1:0] compression;
  logic [1:0] byte_kind;
  logic [7:0] byte_out;

  http_request_header_parser DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .byte_in(byte_in),
    .restart(restart),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .verdict(verdict),
    .compression(compression),
    .byte_kind(byte_kind),
    .byte_out(byte_out)
  );

  // Predicted parser state.
  phase_t     phase_q;
  logic [1:0] enc_q;
  logic [4:0] name_pos_q;
  logic [2:0] name_hits_q;
  logic [2:0] gzip_prog_q;
  logic [2:0] deflate_prog_q;
  logic [1:0] seen_q;

  result_t    pending_results[$];
  logic [7:0] req_bytes[$];

  int errors;
  int items_sent;
  int results_seen;
  int done_seen;
  int bad_seen;
  int captured_seen;
  int gzip_seen;
  int deflate_seen;
  int burst_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Generous bound on the whole run.
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- byte classes

  function automatic bit ctl_byte(logic [7:0] b);
    return (b <= 8'd31) || (b == 8'd127);
  endfunction

  function automatic bit separator_byte(logic [7:0] b);
    case (b)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "?", "=", "{", "}",
      " ", TAB: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit token_byte(logic [7:0] b);
    return (b < 8'd128) && !ctl_byte(b) && !separator_byte(b);
  endfunction

  function automatic bit digit_byte(logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic [7:0] fold_case(logic [7:0] b);
    return ((b >= "A") && (b <= "Z")) ? b + 8'd32 : b;
  endfunction

  function automatic string header_text(int which);
    case (which)
      HDR_AE:  return "accept-encoding";
      HDR_REF: return "referer";
      default: return "user-agent";
    endcase
  endfunction

  // One step of a substring search; hit is set once the whole pattern has been seen.
  function automatic logic [2:0] scan_step(logic [2:0] prog, string pat, logic [7:0] b,
                                           output bit hit);
    hit = 1'b0;
    if (prog >= pat.len()) begin
      hit = 1'b1;
      return 3'(pat.len());
    end
    if (b == pat[prog]) begin
      if (prog + 1 == pat.len()) hit = 1'b1;
      return 3'(prog + 1);
    end
    return (b == pat[0]) ? 3'd1 : 3'd0;
  endfunction

  // ---------------------------------------------------------------- predictor

  task automatic clear_parser();
    phase_q        = PH_METHOD_START;
    enc_q          = ENC_NONE;
    name_pos_q     = '0;
    name_hits_q    = '0;
    gzip_prog_q    = '0;
    deflate_prog_q = '0;
    seen_q         = '0;
  endtask

  task automatic absorb_name_byte(input logic [7:0] b);
    logic [7:0] lb;
    string s;
    lb = fold_case(b);
    for (int i = 0; i < 3; i++) begin
      s = header_text(i);
      if (name_hits_q[i] && ((name_pos_q >= s.len()) || (lb != s[name_pos_q])))
        name_hits_q[i] = 1'b0;
    end
    if (name_pos_q < NAME_POS_MAX) name_pos_q++;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic fresh, output result_t r);
    logic [1:0] v;
    logic [1:0] k;
    phase_t nx;
    bit hit_d;
    bit hit_g;
    string s;
    if (fresh) clear_parser();
    v  = VERDICT_MORE;
    k  = KIND_NONE;
    nx = phase_q;
    case (phase_q)
      PH_METHOD_START: if (token_byte(b)) nx = PH_METHOD; else v = VERDICT_BAD;
      PH_METHOD: begin
        if (b == " ") nx = PH_URI;
        else if (!token_byte(b)) v = VERDICT_BAD;
      end
      PH_URI: begin
        if (b == " ") nx = PH_V_H;
        else if (ctl_byte(b)) v = VERDICT_BAD;
        else k = KIND_URI;
      end
      PH_V_H:       if (b == "H") nx = PH_V_T1; else v = VERDICT_BAD;
      PH_V_T1:      if (b == "T") nx = PH_V_T2; else v = VERDICT_BAD;
      PH_V_T2:      if (b == "T") nx = PH_V_P; else v = VERDICT_BAD;
      PH_V_P:       if (b == "P") nx = PH_V_SLASH; else v = VERDICT_BAD;
      PH_V_SLASH:   if (b == "/") nx = PH_MAJ_START; else v = VERDICT_BAD;
      PH_MAJ_START: if (digit_byte(b)) nx = PH_MAJ; else v = VERDICT_BAD;
      PH_MAJ: begin
        if (b == ".") nx = PH_MIN_START;
        else if (!digit_byte(b)) v = VERDICT_BAD;
      end
      PH_MIN_START: if (digit_byte(b)) nx = PH_MIN; else v = VERDICT_BAD;
      PH_MIN: begin
        if (b == CR) nx = PH_NL1;
        else if (!digit_byte(b)) v = VERDICT_BAD;
      end
      PH_NL1: if (b == LF) nx = PH_LINE_START; else v = VERDICT_BAD;
      PH_LINE_START: begin
        // The finished header line's encoding takes effect here, whatever this byte is.
        if (name_hits_q[HDR_AE]) begin
          if (seen_q[FOUND_DEFLATE]) enc_q = ENC_DEFLATE;
          if (seen_q[FOUND_GZIP]) enc_q = ENC_GZIP;
        end
        if (b == CR) nx = PH_NL3;
        else if (!token_byte(b)) v = VERDICT_BAD;
        else begin
          nx             = PH_NAME;
          name_pos_q     = '0;
          name_hits_q    = 3'b111;
          gzip_prog_q    = '0;
          deflate_prog_q = '0;
          seen_q         = '0;
          absorb_name_byte(b);
        end
      end
      PH_NAME: begin
        if (b == ":") begin
          nx = PH_SPACE;
          for (int i = 0; i < 3; i++) begin
            s = header_text(i);
            if (name_pos_q != s.len()) name_hits_q[i] = 1'b0;
          end
        end else if (!token_byte(b)) v = VERDICT_BAD;
        else absorb_name_byte(b);
      end
      PH_SPACE: if (b == " ") nx = PH_VALUE; else v = VERDICT_BAD;
      PH_VALUE: begin
        if (b == CR) nx = PH_NL2;
        else if (ctl_byte(b)) v = VERDICT_BAD;
        else begin
          if (name_hits_q[HDR_AE]) begin
            deflate_prog_q = scan_step(deflate_prog_q, "deflate", fold_case(b), hit_d);
            gzip_prog_q    = scan_step(gzip_prog_q, "gzip", fold_case(b), hit_g);
            if (hit_d) seen_q[FOUND_DEFLATE] = 1'b1;
            if (hit_g) seen_q[FOUND_GZIP] = 1'b1;
          end
          if (name_hits_q[HDR_REF]) k = KIND_REFERER;
          else if (name_hits_q[HDR_UA]) k = KIND_AGENT;
        end
      end
      PH_NL2: if (b == LF) nx = PH_LINE_START; else v = VERDICT_BAD;
      PH_NL3: begin
        if (b == LF) begin
          v  = VERDICT_DONE;
          nx = PH_DONE;
        end else v = VERDICT_BAD;
      end
      PH_DONE: v = VERDICT_DONE;
      default: v = VERDICT_BAD;
    endcase
    if (v == VERDICT_BAD) begin
      nx = PH_ERROR;
      k  = KIND_NONE;
    end
    phase_q       = nx;
    r.verdict     = v;
    r.compression = enc_q;
    r.kind        = k;
    r.data        = (k != KIND_NONE) ? b : 8'h00;
  endtask

  // ---------------------------------------------------------------- sending

  // Mostly back-to-back or short gaps, now and then a long one or a run with none.
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(30, 90);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fresh);
    int gap;
    result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      byte_in  = 8'($urandom_range(0, 255));
      restart  = 1'($urandom_range(0, 1));
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    byte_in  = b;
    restart  = fresh;
    do @(posedge clk); while (in_stall);
    parse_byte(b, fresh, r);
    pending_results = {pending_results, r};
    items_sent++;
  endtask

  task automatic send_request(input logic fresh, input int restart_at);
    for (int i = 0; i < req_bytes.size(); i++)
      send_byte(req_bytes[i], (i == 0) ? fresh : (i == restart_at));
  endtask

  // Hold the input side idle until every outstanding beat has come back.
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- request builders

  task automatic append_byte(input logic [7:0] b);
    req_bytes = {req_bytes, b};
  endtask

  function automatic logic [7:0] rand_token();
    logic [7:0] b;
    do b = 8'($urandom_range(33, 126)); while (!token_byte(b));
    return b;
  endfunction

  function automatic logic [7:0] rand_non_token();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (token_byte(b) || (b == CR));
    return b;
  endfunction

  function automatic logic [7:0] rand_uri_byte();
    return 8'(($urandom_range(0, 3) == 0) ? $urandom_range(128, 255) : $urandom_range(33, 126));
  endfunction

  function automatic logic [7:0] rand_value_byte();
    return 8'(($urandom_range(0, 9) < 7) ? $urandom_range(32, 126) : $urandom_range(128, 255));
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
  endtask

  task automatic add_mixed_case(input string s);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if ((c >= "a") && (c <= "z") && ($urandom_range(0, 1) == 1)) c = c - 8'd32;
      append_byte(c);
    end
  endtask

  function automatic header_kind_t choose_header(header_mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      ENCODING_HEADERS: if (r < 60) return HK_ACCEPT;
      CAPTURE_HEADERS:  if (r < 60) return (r < 30) ? HK_REFERER : HK_AGENT;
      LONG_NAMES:       if (r < 50) return HK_LONG;
      default: ;
    endcase
    return header_kind_t'($urandom_range(0, 5));
  endfunction

  task automatic add_encoding_value();
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 9))
        0, 1: add_mixed_case("gzip");
        2, 3: add_mixed_case("deflate");
        4: add_mixed_case("gzgzip");
        5: add_mixed_case("ddeflate");
        6: add_mixed_case($urandom_range(0, 1) ? "gzi" : "deflat");
        7: add_text(", ");
        8: add_text(";q=0.5");
        default: append_byte(rand_value_byte());
      endcase
    end
  endtask

  task automatic add_header(input header_mix_t mix);
    header_kind_t hk;
    string s;
    int target;
    hk = choose_header(mix);
    case (hk)
      HK_ACCEPT:  add_mixed_case(header_text(HDR_AE));
      HK_REFERER: add_mixed_case(header_text(HDR_REF));
      HK_AGENT:   add_mixed_case(header_text(HDR_UA));
      HK_NEAR: begin
        s = header_text($urandom_range(0, 2));
        case ($urandom_range(0, 2))
          0: s = s.substr(0, s.len() - 2);
          1: s = {s, "s"};
          default: s[$urandom_range(0, s.len() - 1)] = "x";
        endcase
        add_mixed_case(s);
      end
      HK_LONG: begin
        // Known prefix padded past the name length counter's ceiling, or close to it.
        s = $urandom_range(0, 1) ? header_text($urandom_range(0, 2)) : "";
        target = $urandom_range(16, 40);
        add_mixed_case(s);
        repeat (target - s.len()) append_byte(rand_token());
      end
      default: repeat ($urandom_range(1, 8)) append_byte(rand_token());
    endcase
    add_text(": ");
    if (hk == HK_ACCEPT) add_encoding_value();
    else repeat ($urandom_range(0, 12)) append_byte(rand_value_byte());
    append_byte(CR);
    append_byte(LF);
    // A bad byte right after an encoding line still lets that line's choice land.
    if ((hk == HK_ACCEPT) && (mix == ENCODING_HEADERS) && ($urandom_range(0, 9) == 0))
      append_byte(rand_non_token());
  endtask

  task automatic build_request(input header_mix_t mix);
    req_bytes.delete();
    repeat ($urandom_range(1, 6)) append_byte(rand_token());
    append_byte(" ");
    if ($urandom_range(0, 9) != 0)
      repeat ($urandom_range(1, 10)) append_byte(rand_uri_byte());
    add_text(" HTTP/");
    repeat ($urandom_range(1, 2)) append_byte(8'($urandom_range(8'h30, 8'h39)));
    append_byte(".");
    repeat ($urandom_range(1, 2)) append_byte(8'($urandom_range(8'h30, 8'h39)));
    append_byte(CR);
    append_byte(LF);
    repeat ($urandom_range(0, 3)) add_header(mix);
    append_byte(CR);
    append_byte(LF);
    // Bytes after the blank line must keep answering complete.
    repeat ($urandom_range(0, 2)) append_byte(8'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    // Minimal request straight out of reset, then stray bytes after completion.
    req_bytes.delete();
    add_text("G / HTTP/1.1");
    append_byte(CR);
    append_byte(LF);
    append_byte(CR);
    append_byte(LF);
    append_byte(8'hFF);
    append_byte(8'h00);
    send_request(1'b0, -1);
    // Zero byte as a method, then the error phase must hold.
    req_bytes = '{8'h00, 8'hFF};
    send_request(1'b1, -1);
    // Highest token byte, then a high byte inside the method.
    req_bytes = '{"~", 8'h80};
    send_request(1'b1, -1);
    // Lowest token byte, a high URI byte that is captured, then DEL in the URI.
    req_bytes = '{"!", " ", 8'hFF, 8'h7F};
    send_request(1'b1, -1);
  endtask

  task automatic run_requests(input header_mix_t mix, input int quota);
    int stop_at;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      build_request(mix);
      send_request(1'b1, -1);
    end
  endtask

  task automatic test_accept_encoding();
    run_requests(ENCODING_HEADERS, 400);
  endtask

  task automatic test_captures();
    run_requests(CAPTURE_HEADERS, 300);
  endtask

  task automatic test_long_names();
    run_requests(LONG_NAMES, 250);
  endtask

  task automatic test_malformed();
    int stop_at;
    int restart_at;
    stop_at = items_sent + 300;
    while (items_sent < stop_at) begin
      build_request(MIX_HEADERS);
      repeat ($urandom_range(1, 2))
        req_bytes[$urandom_range(0, req_bytes.size() - 1)] =
          $urandom_range(0, 1) ? rand_non_token() : 8'($urandom_range(0, 255));
      restart_at = ($urandom_range(0, 4) == 0) ? $urandom_range(1, req_bytes.size() - 1) : -1;
      send_request($urandom_range(0, 9) != 0, restart_at);
    end
  endtask

  task automatic test_noise();
    repeat (100) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
  endtask

  task automatic test_mixed();
    run_requests(MIX_HEADERS, ITEM_TARGET - items_sent);
  endtask

  // ---------------------------------------------------------------- result side

  initial begin
    int quiet_len;
    int stall_len;
    out_stall = 1'b0;
    forever begin
      quiet_len = ($urandom_range(0, 99) < 8) ? $urandom_range(40, 120) : $urandom_range(0, 5);
      stall_len = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      repeat (quiet_len) begin
        @(negedge clk);
        out_stall = 1'b0;
      end
      repeat (stall_len) begin
        @(negedge clk);
        out_stall = 1'b1;
      end
    end
  end

  task automatic flag_error(input string msg);
    errors++;
    $display("%0t: %s", $time, msg);
  endtask

  task automatic compare_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (got !== want)
      flag_error($sformatf("%s mismatch: expected %0d, actual %0d", what, want, got));
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if ($isunknown(out_valid))
        flag_error($sformatf("out_valid unknown: expected 0 or 1, actual %b", out_valid));
      if (out_valid && !out_stall) begin
        results_seen++;
        if (verdict == VERDICT_DONE) done_seen++;
        if (verdict == VERDICT_BAD) bad_seen++;
        if (byte_kind != KIND_NONE) captured_seen++;
        if (compression == ENC_GZIP) gzip_seen++;
        if (compression == ENC_DEFLATE) deflate_seen++;
        if (pending_results.size() == 0) begin
          flag_error($sformatf("result beat with nothing expected: expected none, actual %0d/%0d/%0d/%0d",
                               verdict, compression, byte_kind, byte_out));
        end else begin
          want = pending_results.pop_front();
          compare_field("verdict", 8'(want.verdict), 8'(verdict));
          compare_field("compression", 8'(want.compression), 8'(compression));
          compare_field("byte_kind", 8'(want.kind), 8'(byte_kind));
          compare_field("byte_out", want.data, byte_out);
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    byte_in       = 8'h00;
    restart       = 1'b0;
    errors        = 0;
    items_sent    = 0;
    results_seen  = 0;
    done_seen     = 0;
    bad_seen      = 0;
    captured_seen = 0;
    gzip_seen     = 0;
    deflate_seen  = 0;
    burst_left    = 0;
    clear_parser();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    wait_for_drain();
    test_accept_encoding();
    wait_for_drain();
    test_captures();
    test_long_names();
    wait_for_drain();
    test_malformed();
    test_noise();
    wait_for_drain();
    test_mixed();
    wait_for_drain();
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes, checked %0d beats: %0d complete, %0d malformed, %0d captured.",
             items_sent, results_seen, done_seen, bad_seen, captured_seen);
    $display("Beats reporting an accepted encoding: %0d gzip, %0d deflate.",
             gzip_seen, deflate_seen);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
